[rtl/multi_pattern_string_matcher_unit_macros.svh]
// assertion macros for the string matcher
`ifndef MULTI_PATTERN_STRING_MATCHER_UNIT_MACROS_SVH
`define MULTI_PATTERN_STRING_MATCHER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MPSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matcher check failed");

// next-cycle implication, checked out of reset
`define MPSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matcher check failed");

`endif

[rtl/mpsm_pkg.sv]
// shared constants and types of the string matcher
package mpsm_pkg;

  localparam int unsigned DEF_MAX_NODES     = 1024;
  localparam int unsigned DEF_MAX_PATTERNS  = 256;
  localparam int unsigned DEF_ALPHABET_SIZE = 26;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned PNUM_W   = 8;

  // command codes
  localparam logic [1:0] CMD_PAT   = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  // write enables of the tables
  typedef struct packed {
    logic child;
    logic link;
    logic term;
    logic hit;
    logic queue;
    logic pend;
  } wen_t;

  // finished result handed to the output stage
  typedef struct packed {
    logic       valid;
    logic       found;
    logic [1:0] status;
  } done_t;

endpackage

[rtl/mpsm_tables.sv]
// trie, link, flag, queue and pattern tables with registered reads
module mpsm_tables #(
  parameter int unsigned MAX_NODES     = mpsm_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_PATTERNS  = mpsm_pkg::DEF_MAX_PATTERNS,
  parameter int unsigned ALPHABET_SIZE = mpsm_pkg::DEF_ALPHABET_SIZE,
  localparam int unsigned NW     = $clog2(MAX_NODES),
  localparam int unsigned CDEPTH = MAX_NODES * ALPHABET_SIZE,
  localparam int unsigned CW     = $clog2(CDEPTH),
  localparam int unsigned PW     = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1
) (
  input  logic                clk_i,
  input  mpsm_pkg::wen_t      wen_i,
  input  logic [CW-1:0]       caddr_i,
  input  logic [NW-1:0]       cwdata_i,
  output logic [NW-1:0]       crdata_o,
  input  logic [NW-1:0]       nraddr_i,
  input  logic [NW-1:0]       nwaddr_i,
  input  logic [NW-1:0]       fail_wdata_i,
  input  logic [NW-1:0]       outl_wdata_i,
  input  logic                term_wdata_i,
  input  logic                hit_wdata_i,
  output logic [NW-1:0]       fail_rdata_o,
  output logic [NW-1:0]       outl_rdata_o,
  output logic                term_rdata_o,
  output logic                hit_rdata_o,
  input  logic [NW-1:0]       qraddr_i,
  input  logic [NW-1:0]       qwaddr_i,
  input  logic [NW-1:0]       qwdata_i,
  output logic [NW-1:0]       qrdata_o,
  input  logic [PW-1:0]       paddr_i,
  input  logic [NW-1:0]       pwdata_i,
  output logic [NW-1:0]       prdata_o
);

  logic [NW-1:0] child_mem [CDEPTH];
  logic [NW-1:0] fail_mem  [MAX_NODES];
  logic [NW-1:0] outl_mem  [MAX_NODES];
  logic          term_mem  [MAX_NODES];
  logic          hit_mem   [MAX_NODES];
  logic [NW-1:0] queue_mem [MAX_NODES];
  logic [NW-1:0] pend_mem  [MAX_PATTERNS];

  // child table, one port
  always_ff @(posedge clk_i) begin
    if (wen_i.child) begin
      child_mem[caddr_i] <= cwdata_i;
    end
    crdata_o <= child_mem[caddr_i];
  end

  // per-node tables, shared read address
  always_ff @(posedge clk_i) begin
    if (wen_i.link) begin
      fail_mem[nwaddr_i] <= fail_wdata_i;
      outl_mem[nwaddr_i] <= outl_wdata_i;
    end
    if (wen_i.term) begin
      term_mem[nwaddr_i] <= term_wdata_i;
    end
    if (wen_i.hit) begin
      hit_mem[nwaddr_i] <= hit_wdata_i;
    end
    fail_rdata_o <= fail_mem[nraddr_i];
    outl_rdata_o <= outl_mem[nraddr_i];
    term_rdata_o <= term_mem[nraddr_i];
    hit_rdata_o  <= hit_mem[nraddr_i];
  end

  // breadth-first queue
  always_ff @(posedge clk_i) begin
    if (wen_i.queue) begin
      queue_mem[qwaddr_i] <= qwdata_i;
    end
    qrdata_o <= queue_mem[qraddr_i];
  end

  // pattern end nodes
  always_ff @(posedge clk_i) begin
    if (wen_i.pend) begin
      pend_mem[paddr_i] <= pwdata_i;
    end
    prdata_o <= pend_mem[paddr_i];
  end

endmodule

[rtl/mpsm_seq.sv]
// sequencer driving the shared slot address unit and the tables
module mpsm_seq #(
  parameter int unsigned MAX_NODES     = mpsm_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_PATTERNS  = mpsm_pkg::DEF_MAX_PATTERNS,
  parameter int unsigned ALPHABET_SIZE = mpsm_pkg::DEF_ALPHABET_SIZE,
  localparam int unsigned NW     = $clog2(MAX_NODES),
  localparam int unsigned CDEPTH = MAX_NODES * ALPHABET_SIZE,
  localparam int unsigned CW     = $clog2(CDEPTH),
  localparam int unsigned PW     = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1,
  localparam int unsigned AW     = $clog2(ALPHABET_SIZE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [1:0]                    cmd_i,
  input  logic [mpsm_pkg::LETTER_W-1:0] letter_i,
  input  logic [mpsm_pkg::PNUM_W-1:0]   pnum_i,
  output logic                          ready_o,
  output mpsm_pkg::done_t               done_o,
  input  logic                          out_free_i,
  output mpsm_pkg::wen_t                wen_o,
  output logic [CW-1:0]                 caddr_o,
  output logic [NW-1:0]                 cwdata_o,
  input  logic [NW-1:0]                 crdata_i,
  output logic [NW-1:0]                 nraddr_o,
  output logic [NW-1:0]                 nwaddr_o,
  output logic [NW-1:0]                 fail_wdata_o,
  output logic [NW-1:0]                 outl_wdata_o,
  output logic                          term_wdata_o,
  output logic                          hit_wdata_o,
  input  logic [NW-1:0]                 fail_rdata_i,
  input  logic [NW-1:0]                 outl_rdata_i,
  input  logic                          term_rdata_i,
  input  logic                          hit_rdata_i,
  output logic [NW-1:0]                 qraddr_o,
  output logic [NW-1:0]                 qwaddr_o,
  output logic [NW-1:0]                 qwdata_o,
  input  logic [NW-1:0]                 qrdata_i,
  output logic [PW-1:0]                 paddr_o,
  output logic [NW-1:0]                 pwdata_o,
  input  logic [NW-1:0]                 prdata_i
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_PWAIT  = 5'd3;
  localparam logic [4:0] S_PCHK   = 5'd4;
  localparam logic [4:0] S_FSET   = 5'd5;
  localparam logic [4:0] S_FWAIT  = 5'd6;
  localparam logic [4:0] S_FEVAL  = 5'd7;
  localparam logic [4:0] S_WSET   = 5'd8;
  localparam logic [4:0] S_WWAIT  = 5'd9;
  localparam logic [4:0] S_WEVAL  = 5'd10;
  localparam logic [4:0] S_QSET   = 5'd11;
  localparam logic [4:0] S_QWAIT  = 5'd12;
  localparam logic [4:0] S_QEVAL  = 5'd13;
  localparam logic [4:0] S_RPOP   = 5'd14;
  localparam logic [4:0] S_RWAIT  = 5'd15;
  localparam logic [4:0] S_RV     = 5'd16;
  localparam logic [4:0] S_RVWAIT = 5'd17;
  localparam logic [4:0] S_RV2    = 5'd18;
  localparam logic [4:0] S_CSET   = 5'd19;
  localparam logic [4:0] S_CWAIT  = 5'd20;
  localparam logic [4:0] S_CEVAL  = 5'd21;
  localparam logic [4:0] S_LSET   = 5'd22;
  localparam logic [4:0] S_LWAIT  = 5'd23;
  localparam logic [4:0] S_LEVAL  = 5'd24;
  localparam logic [4:0] S_DONE   = 5'd25;

  localparam logic [NW:0]   NODE_LIM = (NW + 1)'(MAX_NODES);
  localparam logic [CW-1:0] CLR_LAST = CW'(CDEPTH - 1);
  localparam logic [AW-1:0] C_LAST   = AW'(ALPHABET_SIZE - 1);

  logic [4:0]                    state_q, state_d;
  logic [1:0]                    cmd_q, cmd_d;
  logic [mpsm_pkg::LETTER_W-1:0] letter_q, letter_d;
  logic [mpsm_pkg::PNUM_W-1:0]   pnum_q, pnum_d;
  logic [NW-1:0]                 cursor_q, cursor_d;
  logic [NW-1:0]                 cur_q, cur_d;
  logic [NW:0]                   count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic                          rpend_q, rpend_d;
  logic [MAX_PATTERNS-1:0]       valid_q, valid_d;
  logic [CW-1:0]                 caddr_q, caddr_d;
  logic [NW-1:0]                 naddr_q, naddr_d;
  logic [NW-1:0]                 fv_q, fv_d;
  logic                          in_bfs_q, in_bfs_d;
  logic [NW:0]                   head_q, head_d;
  logic [NW:0]                   tail_q, tail_d;
  logic [NW-1:0]                 v_q, v_d;
  logic [NW-1:0]                 bfail_q, bfail_d;
  logic [AW-1:0]                 c_q, c_d;
  logic [NW-1:0]                 u_q, u_d;
  logic [NW-1:0]                 f_q, f_d;
  logic [NW-1:0]                 j_q, j_d;
  logic                          found_q, found_d;
  logic [1:0]                    status_q, status_d;

  logic [NW-1:0] sl_v;
  logic [CW-1:0] sl_c;
  logic [CW-1:0] slot;
  logic [PW-1:0] pidx;
  logic          letter_ok;
  logic          pnum_ok;

  // shared slot address unit: node times alphabet plus letter
  assign slot = CW'(sl_v) * CW'(ALPHABET_SIZE) + sl_c;

  assign pidx      = PW'(pnum_q);
  assign letter_ok = {4'b0, letter_q} < 9'(ALPHABET_SIZE);
  assign pnum_ok   = {5'b0, pnum_q} < 13'(MAX_PATTERNS);

  assign ready_o       = (state_q == S_IDLE);
  assign done_o.valid  = (state_q == S_DONE);
  assign done_o.found  = found_q;
  assign done_o.status = status_q;

  assign caddr_o  = caddr_q;
  assign nraddr_o = naddr_q;
  assign qraddr_o = head_q[NW-1:0];
  assign paddr_o  = pidx;

  // next-state and table control
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    letter_d = letter_q;
    pnum_d   = pnum_q;
    cursor_d = cursor_q;
    cur_d    = cur_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    rpend_d  = rpend_q;
    valid_d  = valid_q;
    caddr_d  = caddr_q;
    naddr_d  = naddr_q;
    fv_d     = fv_q;
    in_bfs_d = in_bfs_q;
    head_d   = head_q;
    tail_d   = tail_q;
    v_d      = v_q;
    bfail_d  = bfail_q;
    c_d      = c_q;
    u_d      = u_q;
    f_d      = f_q;
    j_d      = j_q;
    found_d  = found_q;
    status_d = status_q;

    wen_o        = '0;
    cwdata_o     = count_q[NW-1:0];
    nwaddr_o     = u_q;
    fail_wdata_o = f_q;
    outl_wdata_o = term_rdata_i ? f_q : outl_rdata_i;
    term_wdata_o = 1'b1;
    hit_wdata_o  = 1'b1;
    qwaddr_o     = tail_q[NW-1:0];
    qwdata_o     = u_q;
    pwdata_o     = cursor_q;
    sl_v         = fv_q;
    sl_c         = in_bfs_q ? CW'(c_q) : CW'(letter_q);

    case (state_q)
      // sweep the child, link, terminal and hit tables to their empty value
      S_CLR: begin
        wen_o.child  = 1'b1;
        cwdata_o     = '0;
        nwaddr_o     = caddr_q[NW-1:0];
        fail_wdata_o = '0;
        outl_wdata_o = '0;
        term_wdata_o = 1'b0;
        hit_wdata_o  = 1'b0;
        if (caddr_q < CW'(MAX_NODES)) begin
          wen_o.link = 1'b1;
          wen_o.term = 1'b1;
          wen_o.hit  = 1'b1;
        end
        caddr_d = caddr_q + 1'b1;
        if (caddr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc_i) begin
          cmd_d    = cmd_i;
          letter_d = letter_i;
          pnum_d   = pnum_i;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        found_d  = 1'b0;
        status_d = mpsm_pkg::ST_OK;
        state_d  = S_DONE;
        case (cmd_q)
          mpsm_pkg::CMD_PAT: begin
            if (ovf_q) begin
              status_d = mpsm_pkg::ST_FULL;
            end else if (letter_ok) begin
              sl_v    = cursor_q;
              sl_c    = CW'(letter_q);
              caddr_d = slot;
              state_d = S_PWAIT;
            end
          end
          mpsm_pkg::CMD_END: begin
            if (!pnum_ok) begin
              status_d = mpsm_pkg::ST_UNDEF;
            end else if (ovf_q) begin
              valid_d[pidx] = 1'b0;
              status_d      = mpsm_pkg::ST_FULL;
            end else begin
              wen_o.pend    = 1'b1;
              valid_d[pidx] = 1'b1;
              wen_o.term    = 1'b1;
              nwaddr_o      = cursor_q;
              rpend_d       = 1'b1;
            end
            cursor_d = '0;
            ovf_d    = 1'b0;
          end
          mpsm_pkg::CMD_TEXT: begin
            if (!letter_ok) begin
              cur_d = '0;
            end else if (rpend_q) begin
              wen_o.queue = 1'b1;
              qwaddr_o    = '0;
              qwdata_o    = '0;
              head_d      = '0;
              tail_d      = (NW + 1)'(1);
              in_bfs_d    = 1'b1;
              state_d     = S_RPOP;
            end else begin
              fv_d     = cur_q;
              in_bfs_d = 1'b0;
              state_d  = S_FSET;
            end
          end
          default: begin
            if (!pnum_ok || !valid_q[pidx]) begin
              status_d = mpsm_pkg::ST_UNDEF;
            end else begin
              state_d = S_QSET;
            end
          end
        endcase
      end
      // pattern letter: extend the trie by one step
      S_PWAIT: state_d = S_PCHK;
      S_PCHK: begin
        state_d = S_DONE;
        if (crdata_i == '0) begin
          if (count_q >= NODE_LIM) begin
            ovf_d    = 1'b1;
            status_d = mpsm_pkg::ST_FULL;
          end else begin
            wen_o.child = 1'b1;
            cursor_d    = count_q[NW-1:0];
            count_d     = count_q + 1'b1;
            rpend_d     = 1'b1;
          end
        end else begin
          cursor_d = crdata_i;
        end
      end
      // goto with failure fallback
      S_FSET: begin
        caddr_d = slot;
        naddr_d = fv_q;
        state_d = S_FWAIT;
      end
      S_FWAIT: state_d = S_FEVAL;
      S_FEVAL: begin
        if (crdata_i != '0 || fv_q == '0) begin
          if (in_bfs_q) begin
            f_d     = crdata_i;
            state_d = S_LSET;
          end else begin
            cur_d   = crdata_i;
            j_d     = crdata_i;
            state_d = S_WSET;
          end
        end else begin
          fv_d    = fail_rdata_i;
          state_d = S_FSET;
        end
      end
      // output link walk setting hit flags
      S_WSET: begin
        naddr_d = j_q;
        state_d = S_WWAIT;
      end
      S_WWAIT: state_d = S_WEVAL;
      S_WEVAL: begin
        if (term_rdata_i) begin
          wen_o.hit = 1'b1;
          nwaddr_o  = j_q;
        end
        if (j_q == '0) begin
          state_d = S_DONE;
        end else begin
          j_d     = outl_rdata_i;
          state_d = S_WSET;
        end
      end
      // query: end node then its hit flag
      S_QSET: begin
        naddr_d = prdata_i;
        state_d = S_QWAIT;
      end
      S_QWAIT: state_d = S_QEVAL;
      S_QEVAL: begin
        found_d = hit_rdata_i;
        state_d = S_DONE;
      end
      // breadth-first link rebuild
      S_RPOP: begin
        if (head_q == tail_q) begin
          rpend_d  = 1'b0;
          in_bfs_d = 1'b0;
          fv_d     = cur_q;
          state_d  = S_FSET;
        end else begin
          state_d = S_RWAIT;
        end
      end
      S_RWAIT: state_d = S_RV;
      S_RV: begin
        v_d     = qrdata_i;
        naddr_d = qrdata_i;
        head_d  = head_q + 1'b1;
        c_d     = '0;
        state_d = S_RVWAIT;
      end
      S_RVWAIT: state_d = S_RV2;
      S_RV2: begin
        bfail_d = fail_rdata_i;
        state_d = S_CSET;
      end
      S_CSET: begin
        sl_v    = v_q;
        sl_c    = CW'(c_q);
        caddr_d = slot;
        state_d = S_CWAIT;
      end
      S_CWAIT: state_d = S_CEVAL;
      S_CEVAL: begin
        u_d = crdata_i;
        if (crdata_i == '0 || tail_q >= NODE_LIM) begin
          if (c_q == C_LAST) begin
            state_d = S_RPOP;
          end else begin
            c_d     = c_q + 1'b1;
            state_d = S_CSET;
          end
        end else if (v_q == '0) begin
          f_d     = '0;
          state_d = S_LSET;
        end else begin
          fv_d    = bfail_q;
          state_d = S_FSET;
        end
      end
      S_LSET: begin
        naddr_d = f_q;
        state_d = S_LWAIT;
      end
      S_LWAIT: state_d = S_LEVAL;
      S_LEVAL: begin
        wen_o.link  = 1'b1;
        wen_o.queue = 1'b1;
        tail_d      = tail_q + 1'b1;
        if (c_q == C_LAST) begin
          state_d = S_RPOP;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_CSET;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cmd_q    <= mpsm_pkg::CMD_PAT;
      letter_q <= '0;
      pnum_q   <= '0;
      cursor_q <= '0;
      cur_q    <= '0;
      count_q  <= (NW + 1)'(1);
      ovf_q    <= 1'b0;
      rpend_q  <= 1'b0;
      valid_q  <= '0;
      caddr_q  <= '0;
      naddr_q  <= '0;
      fv_q     <= '0;
      in_bfs_q <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      v_q      <= '0;
      bfail_q  <= '0;
      c_q      <= '0;
      u_q      <= '0;
      f_q      <= '0;
      j_q      <= '0;
      found_q  <= 1'b0;
      status_q <= mpsm_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      letter_q <= letter_d;
      pnum_q   <= pnum_d;
      cursor_q <= cursor_d;
      cur_q    <= cur_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      rpend_q  <= rpend_d;
      valid_q  <= valid_d;
      caddr_q  <= caddr_d;
      naddr_q  <= naddr_d;
      fv_q     <= fv_d;
      in_bfs_q <= in_bfs_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      v_q      <= v_d;
      bfail_q  <= bfail_d;
      c_q      <= c_d;
      u_q      <= u_d;
      f_q      <= f_d;
      j_q      <= j_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

endmodule

[rtl/multi_pattern_string_matcher_unit.sv]
// top level of the multi-pattern string matcher
// Aho-Corasick matcher. One command word enters on the s_axis side, one
// result word leaves on the m_axis side for every command.
// s_axis: tuser is the command (pattern letter, end pattern, text letter,
// query); tdata carries the letter and the pattern number.
// m_axis: tdata bit 0 is the found flag of a query, tuser the status.
// Per word, from accept to result: a pattern letter reads its child slot
// (not when ignored or full), an end pattern only writes its tables, a
// query reads the end node then its hit flag (not when undefined), and a
// text letter takes goto/failure steps, then walks the output link chain.
// A text letter after the trie or the pattern set changed first rebuilds
// the failure links: it pops each queued node, reads each alphabet slot
// and writes the links of each child after its failure steps. All of it runs
// through one child table port and one shared slot address unit, one
// command at a time. After reset the block sweeps the child table, all
// MAX_NODES * ALPHABET_SIZE slots (26624 by default), with s_axis_tready low.
// A result waits in the output register while m_axis_tready is low; the
// next command is still taken and runs until it too needs that register.
`include "multi_pattern_string_matcher_unit_macros.svh"

module multi_pattern_string_matcher_unit #(
  parameter int unsigned MAX_NODES     = mpsm_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_PATTERNS  = mpsm_pkg::DEF_MAX_PATTERNS,
  parameter int unsigned ALPHABET_SIZE = mpsm_pkg::DEF_ALPHABET_SIZE,
  localparam int unsigned NW = $clog2(MAX_NODES),
  localparam int unsigned CW = $clog2(MAX_NODES * ALPHABET_SIZE),
  localparam int unsigned PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // letter[4:0], pattern_number[12:5], zero pad
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // found[0], zero pad
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  mpsm_pkg::wen_t  wen;
  mpsm_pkg::done_t done;
  logic            acc;
  logic            out_free;
  logic            m_valid_q;
  logic            m_found_q;
  logic [1:0]      m_status_q;

  logic [CW-1:0] caddr;
  logic [NW-1:0] cwdata, crdata;
  logic [NW-1:0] nraddr, nwaddr, fail_wd, outl_wd, fail_rd, outl_rd;
  logic          term_wd, hit_wd, term_rd, hit_rd;
  logic [NW-1:0] qraddr, qwaddr, qwdata, qrdata;
  logic [PW-1:0] paddr;
  logic [NW-1:0] pwdata, prdata;

  assign acc      = s_axis_tvalid & s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  mpsm_seq #(
    .MAX_NODES    (MAX_NODES),
    .MAX_PATTERNS (MAX_PATTERNS),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .cmd_i       (s_axis_tuser),
    .letter_i    (s_axis_tdata[4:0]),
    .pnum_i      (s_axis_tdata[12:5]),
    .ready_o     (s_axis_tready),
    .done_o      (done),
    .out_free_i  (out_free),
    .wen_o       (wen),
    .caddr_o     (caddr),
    .cwdata_o    (cwdata),
    .crdata_i    (crdata),
    .nraddr_o    (nraddr),
    .nwaddr_o    (nwaddr),
    .fail_wdata_o(fail_wd),
    .outl_wdata_o(outl_wd),
    .term_wdata_o(term_wd),
    .hit_wdata_o (hit_wd),
    .fail_rdata_i(fail_rd),
    .outl_rdata_i(outl_rd),
    .term_rdata_i(term_rd),
    .hit_rdata_i (hit_rd),
    .qraddr_o    (qraddr),
    .qwaddr_o    (qwaddr),
    .qwdata_o    (qwdata),
    .qrdata_i    (qrdata),
    .paddr_o     (paddr),
    .pwdata_o    (pwdata),
    .prdata_i    (prdata)
  );

  mpsm_tables #(
    .MAX_NODES    (MAX_NODES),
    .MAX_PATTERNS (MAX_PATTERNS),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_tables (
    .clk_i       (clk_i),
    .wen_i       (wen),
    .caddr_i     (caddr),
    .cwdata_i    (cwdata),
    .crdata_o    (crdata),
    .nraddr_i    (nraddr),
    .nwaddr_i    (nwaddr),
    .fail_wdata_i(fail_wd),
    .outl_wdata_i(outl_wd),
    .term_wdata_i(term_wd),
    .hit_wdata_i (hit_wd),
    .fail_rdata_o(fail_rd),
    .outl_rdata_o(outl_rd),
    .term_rdata_o(term_rd),
    .hit_rdata_o (hit_rd),
    .qraddr_i    (qraddr),
    .qwaddr_i    (qwaddr),
    .qwdata_i    (qwdata),
    .qrdata_o    (qrdata),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done.valid && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid && out_free) begin
      m_found_q  <= done.found;
      m_status_q <= done.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_found_q};
  assign m_axis_tuser  = m_status_q;

  // a taken word keeps the block busy in the next cycle
  `MPSM_ASSERT_NEXT(a_busy_after_accept, acc, !s_axis_tready)
  // a set found flag only comes with an ok status
  `MPSM_ASSERT_NOW(a_found_ok, m_axis_tvalid && m_axis_tdata[0], m_axis_tuser == mpsm_pkg::ST_OK)
  // a finished result is never lost while the output waits
  `MPSM_ASSERT_NEXT(a_result_held, done.valid && !out_free, done.valid && m_axis_tvalid)

endmodule

[tb/multi_pattern_string_matcher_unit_tb.sv]
// testbench of the multi-pattern string matcher: directed, random and table-full tests
`timescale 1ns / 1ps

module multi_pattern_string_matcher_unit_tb;

  localparam int unsigned NODES    = mpsm_pkg::DEF_MAX_NODES;
  localparam int unsigned PATTERNS = mpsm_pkg::DEF_MAX_PATTERNS;
  localparam int unsigned ALPHA    = mpsm_pkg::DEF_ALPHABET_SIZE;
  localparam int          RANDOM_WORDS = 1650 - int'(NODES);

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = mpsm_pkg::CMD_PAT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // matcher state mirror
  int unsigned trie_child [NODES*ALPHA];
  int unsigned fail_of [NODES];
  int unsigned next_out [NODES];
  bit          is_term [NODES];
  bit          was_hit [NODES];
  int unsigned end_node [PATTERNS];
  bit          end_valid [PATTERNS];
  int unsigned bfs_fifo [NODES];
  int unsigned used_nodes;
  int unsigned cursor;
  int unsigned text_node;
  bit          overflowed;
  bit          links_stale;

  answer_t answers_due [$];
  int      fail_count = 0;
  int      words_sent = 0;
  bit      calm = 1'b0;

  always #5 clk_i = ~clk_i;

  multi_pattern_string_matcher_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // goto along failure links until a child exists
  function automatic int unsigned walk_goto(int unsigned v, int unsigned c);
    while (v != 0 && trie_child[v*ALPHA+c] == 0) v = fail_of[v];
    return trie_child[v*ALPHA+c];
  endfunction

  // breadth-first rebuild of failure and output links
  task automatic relink();
    int unsigned head;
    int unsigned tail;
    int unsigned v;
    int unsigned u;
    int unsigned f;
    head = 0;
    tail = 0;
    fail_of[0] = 0;
    next_out[0] = 0;
    bfs_fifo[tail] = 0;
    tail = tail + 1;
    while (head < tail) begin
      v = bfs_fifo[head];
      head = head + 1;
      for (int unsigned c = 0; c < ALPHA; c++) begin
        u = trie_child[v*ALPHA+c];
        if (u != 0 && tail < NODES) begin
          f = (v == 0) ? 0 : walk_goto(fail_of[v], c);
          fail_of[u] = f;
          next_out[u] = is_term[f] ? f : next_out[f];
          bfs_fifo[tail] = u;
          tail = tail + 1;
        end
      end
    end
    links_stale = 1'b0;
  endtask

  task automatic clear_mirror();
    foreach (trie_child[i]) trie_child[i] = 0;
    foreach (fail_of[i]) begin
      fail_of[i] = 0;
      next_out[i] = 0;
      is_term[i] = 1'b0;
      was_hit[i] = 1'b0;
    end
    foreach (end_node[i]) begin
      end_node[i] = 0;
      end_valid[i] = 1'b0;
    end
    used_nodes = 1;
    cursor = 0;
    text_node = 0;
    overflowed = 1'b0;
    links_stale = 1'b0;
  endtask

  // expected answer of one command word
  task automatic match_step(input logic [1:0] cmd, input int unsigned ltr,
                            input int unsigned pn, output answer_t ans);
    int unsigned slot;
    int unsigned j;
    ans = '{found: 1'b0, status: mpsm_pkg::ST_OK};
    case (cmd)
      mpsm_pkg::CMD_PAT: begin
        if (overflowed) begin
          ans.status = mpsm_pkg::ST_FULL;
        end else if (ltr < ALPHA) begin
          slot = cursor*ALPHA + ltr;
          if (trie_child[slot] == 0) begin
            if (used_nodes >= NODES) begin
              overflowed = 1'b1;
              ans.status = mpsm_pkg::ST_FULL;
            end else begin
              trie_child[slot] = used_nodes;
              used_nodes++;
              links_stale = 1'b1;
            end
          end
          if (!overflowed) cursor = trie_child[slot];
        end
      end
      mpsm_pkg::CMD_END: begin
        if (pn >= PATTERNS) begin
          ans.status = mpsm_pkg::ST_UNDEF;
        end else if (overflowed) begin
          end_valid[pn] = 1'b0;
          end_node[pn] = 0;
          ans.status = mpsm_pkg::ST_FULL;
        end else begin
          end_node[pn] = cursor;
          end_valid[pn] = 1'b1;
          if (!is_term[cursor]) begin
            is_term[cursor] = 1'b1;
            links_stale = 1'b1;
          end
        end
        cursor = 0;
        overflowed = 1'b0;
      end
      mpsm_pkg::CMD_TEXT: begin
        if (ltr >= ALPHA) begin
          text_node = 0;
        end else begin
          if (links_stale) relink();
          text_node = walk_goto(text_node, ltr);
          j = text_node;
          forever begin
            if (is_term[j]) was_hit[j] = 1'b1;
            if (j == 0) break;
            j = next_out[j];
          end
        end
      end
      default: begin
        if (pn >= PATTERNS || !end_valid[pn]) ans.status = mpsm_pkg::ST_UNDEF;
        else ans.found = was_hit[end_node[pn]];
      end
    endcase
  endtask

  // send one command word and record its expected answer on acceptance
  task automatic send_word(input logic [1:0] cmd, input int unsigned ltr,
                           input int unsigned pn);
    answer_t ans;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {3'b000, pn[7:0], ltr[4:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    match_step(cmd, ltr, pn, ans);
    answers_due.push_back(ans);
    words_sent++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // random back pressure on the result side
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 38);
  end

  // compare each result word with the oldest expected answer
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result word found=%0b status=%0d", $realtime,
                 m_axis_tdata[0], m_axis_tuser);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tdata[0] !== want.found) begin
          $display("%0t: found mismatch expected %0b actual %0b", $realtime,
                   want.found, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                   want.status, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // duplicates, empty pattern, redefinition, bad letters, undefined queries
  task automatic test_directed();
    send_word(mpsm_pkg::CMD_PAT, 0, 0);
    send_word(mpsm_pkg::CMD_PAT, 31, 0);
    send_word(mpsm_pkg::CMD_PAT, 1, 0);
    send_word(mpsm_pkg::CMD_END, 0, 0);
    send_word(mpsm_pkg::CMD_PAT, 1, 0);
    send_word(mpsm_pkg::CMD_END, 0, 1);
    send_word(mpsm_pkg::CMD_PAT, 0, 0);
    send_word(mpsm_pkg::CMD_PAT, 1, 0);
    send_word(mpsm_pkg::CMD_END, 0, 2);
    send_word(mpsm_pkg::CMD_END, 0, 3);
    send_word(mpsm_pkg::CMD_QUERY, 0, 4);
    send_word(mpsm_pkg::CMD_TEXT, 0, 0);
    send_word(mpsm_pkg::CMD_TEXT, 1, 0);
    send_word(mpsm_pkg::CMD_TEXT, 30, 0);
    send_word(mpsm_pkg::CMD_TEXT, 25, 0);
    for (int unsigned p = 0; p < 5; p++) send_word(mpsm_pkg::CMD_QUERY, 0, p);
    send_word(mpsm_pkg::CMD_QUERY, 31, 255);
    send_word(mpsm_pkg::CMD_PAT, 1, 0);
    send_word(mpsm_pkg::CMD_PAT, 0, 0);
    send_word(mpsm_pkg::CMD_END, 0, 1);
    send_word(mpsm_pkg::CMD_QUERY, 0, 1);
  endtask

  // rounds of patterns, text runs and queries over a small alphabet
  task automatic test_random();
    int round;
    round = 0;
    while (words_sent < RANDOM_WORDS) begin
      calm = (round >= 12 && round < 20);
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 3))
          send_word(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 255));
      end
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 99) < 8)
            send_word(mpsm_pkg::CMD_PAT, $urandom_range(26, 31), 0);
          else if ($urandom_range(0, 99) < 1)
            send_word(mpsm_pkg::CMD_PAT, $urandom_range(0, 25), 0);
          else send_word(mpsm_pkg::CMD_PAT, $urandom_range(0, 2), $urandom_range(0, 255));
        end
        send_word(mpsm_pkg::CMD_END, $urandom_range(0, 31),
                  ($urandom_range(0, 99) < 85) ? $urandom_range(0, 15) : $urandom_range(0, 255));
      end
      repeat ($urandom_range(6, 16)) begin
        if ($urandom_range(0, 99) < 6) send_word(mpsm_pkg::CMD_TEXT, $urandom_range(26, 31), 0);
        else send_word(mpsm_pkg::CMD_TEXT, $urandom_range(0, 2), $urandom_range(0, 255));
      end
      repeat ($urandom_range(2, 6))
        send_word(mpsm_pkg::CMD_QUERY, $urandom_range(0, 31),
                  ($urandom_range(0, 99) < 85) ? $urandom_range(0, 15) : $urandom_range(0, 255));
      round++;
    end
    calm = 1'b0;
  endtask

  // grow one long chain until the node table runs out
  task automatic test_table_full();
    while (used_nodes < NODES) send_word(mpsm_pkg::CMD_PAT, 24, 0);
    repeat (3) send_word(mpsm_pkg::CMD_PAT, 24, 0);
    send_word(mpsm_pkg::CMD_END, 0, 1);
    send_word(mpsm_pkg::CMD_QUERY, 0, 1);
    send_word(mpsm_pkg::CMD_PAT, 0, 0);
    send_word(mpsm_pkg::CMD_PAT, 1, 0);
    send_word(mpsm_pkg::CMD_PAT, 23, 0);
    send_word(mpsm_pkg::CMD_PAT, 0, 0);
    send_word(mpsm_pkg::CMD_END, 0, 6);
    send_word(mpsm_pkg::CMD_PAT, 0, 0);
    send_word(mpsm_pkg::CMD_PAT, 1, 0);
    send_word(mpsm_pkg::CMD_END, 0, 5);
    repeat (3) send_word(mpsm_pkg::CMD_TEXT, 24, 0);
    send_word(mpsm_pkg::CMD_TEXT, 0, 0);
    send_word(mpsm_pkg::CMD_TEXT, 1, 0);
    for (int unsigned p = 0; p < 7; p++) send_word(mpsm_pkg::CMD_QUERY, 0, p);
  endtask

  initial begin
    clear_mirror();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_table_full();
    s_axis_tvalid = 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[multi_pattern_string_matcher_unit.f]
+incdir+rtl
rtl/mpsm_pkg.sv
rtl/mpsm_tables.sv
rtl/mpsm_seq.sv
rtl/multi_pattern_string_matcher_unit.sv
tb/multi_pattern_string_matcher_unit_tb.sv
